@@ rtl/lob_pkg.sv @@
// Shared types and constants for the price-time priority order book matcher.
`default_nettype none
package lob_pkg;

  // Resting orders held on each side of the book
  localparam int unsigned ORDERS_PER_SIDE = 32;
  localparam int unsigned IDXW = (ORDERS_PER_SIDE > 1) ? $clog2(ORDERS_PER_SIDE) : 1;

  // Request type codes
  localparam logic [1:0] REQ_LIMIT  = 2'd0;
  localparam logic [1:0] REQ_MARKET = 2'd1;

  // Side codes
  localparam logic [1:0] SIDE_BUY  = 2'd0;
  localparam logic [1:0] SIDE_SELL = 2'd1;

  // Result kinds
  localparam logic [2:0] KIND_TRADE  = 3'd0;
  localparam logic [2:0] KIND_RESTED = 3'd1;
  localparam logic [2:0] KIND_DONE   = 3'd2;
  localparam logic [2:0] KIND_REJECT = 3'd3;
  localparam logic [2:0] KIND_FULL   = 3'd4;

  // Slot write operations
  typedef enum logic [1:0] {
    WR_SET_QTY,
    WR_CLEAR,
    WR_INSERT
  } wr_op_t;

  // Broadcast write to the cells
  typedef struct packed {
    logic            en;
    logic            ask;
    logic [IDXW-1:0] idx;
    wr_op_t          op;
    logic [31:0]     price;
    logic [31:0]     qty;
    logic [31:0]     oid;
    logic [31:0]     trader;
    logic [31:0]     arrival;
  } wr_t;

  // Running search result passed from cell to cell
  typedef struct packed {
    logic            tok;
    logic            found;
    logic [IDXW-1:0] idx;
    logic [31:0]     price;
    logic [31:0]     qty;
    logic [31:0]     oid;
    logic [31:0]     trader;
    logic [31:0]     arrival;
    logic            free_found;
    logic [IDXW-1:0] free_idx;
  } cand_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_WAIT,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

@@ rtl/limit_order_book_matcher.sv @@
// Top level of the price-time priority limit order book matcher.
// Takes one order per item and returns its trades followed by one status item
// with last set. Each search for the best resting order walks the
// ORDERS_PER_SIDE cells of both book sides in parallel, one cell per cycle.
// Rejected and zero-quantity orders skip the search and go straight to the
// status item. No new order is taken until the status item of the current
// one has been delivered.
`default_nettype none
module limit_order_book_matcher (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  req_type,
  input  wire  [1:0]  book_side,
  input  wire  [31:0] order_quantity,
  input  wire  [31:0] limit_price,
  input  wire  [31:0] taker_trader,
  input  wire         replay,
  input  wire  [31:0] replay_time,
  input  wire  [31:0] replay_order_id,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [2:0]  result_kind,
  output logic [31:0] trade_price,
  output logic [31:0] trade_quantity,
  output logic [31:0] maker_order_id,
  output logic [31:0] maker_trader,
  output logic [31:0] maker_left,
  output logic [31:0] taker_id_out,
  output logic [31:0] event_time,
  output logic        maker_is_ask,
  output logic [31:0] rested_id,
  output logic        last
);
  import lob_pkg::*;

  state_t      state, state_next;
  logic [31:0] book_clock, book_clock_next;
  logic [31:0] order_counter, order_counter_next;
  logic [31:0] arrival_counter, arrival_counter_next;

  // Current order
  logic        ord_market, ord_market_next;
  logic        ord_sell, ord_sell_next;
  logic [31:0] ord_qty, ord_qty_next;
  logic [31:0] ord_price, ord_price_next;
  logic [31:0] ord_taker, ord_taker_next;
  logic [31:0] ord_id, ord_id_next;

  // Output register next values
  logic        out_valid_next;
  logic [2:0]  kind_next;
  logic [31:0] tprice_next, tqty_next, mid_next, mtr_next, mleft_next, rid_next;
  logic        mask_next, last_next;

  wr_t         wr;
  logic        seed;
  cand_t       bid_tail, ask_tail, opp, own;
  logic        cross_ok, smaller;
  logic [31:0] clk_new;

  lob_chain u_bids (
    .clk(clk), .rst(rst), .is_ask(1'b0), .seed(seed), .wr(wr), .tail(bid_tail)
  );
  lob_chain u_asks (
    .clk(clk), .rst(rst), .is_ask(1'b1), .seed(seed), .wr(wr), .tail(ask_tail)
  );

  assign opp = ord_sell ? bid_tail : ask_tail;
  assign own = ord_sell ? ask_tail : bid_tail;
  assign cross_ok = ord_market || (ord_sell ? (ord_price <= opp.price)
                                            : (ord_price >= opp.price));
  assign smaller = ord_qty < opp.qty;
  assign clk_new = replay ? replay_time : book_clock + 32'd1;
  assign in_ready = (state == ST_IDLE);
  assign seed = (state == ST_LAUNCH);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      book_clock      <= '0;
      order_counter   <= '0;
      arrival_counter <= '0;
      out_valid       <= 1'b0;
    end else begin
      state           <= state_next;
      book_clock      <= book_clock_next;
      order_counter   <= order_counter_next;
      arrival_counter <= arrival_counter_next;
      out_valid       <= out_valid_next;
    end
  end

  // Order and result payload
  always_ff @(posedge clk) begin
    ord_market     <= ord_market_next;
    ord_sell       <= ord_sell_next;
    ord_qty        <= ord_qty_next;
    ord_price      <= ord_price_next;
    ord_taker      <= ord_taker_next;
    ord_id         <= ord_id_next;
    result_kind    <= kind_next;
    trade_price    <= tprice_next;
    trade_quantity <= tqty_next;
    maker_order_id <= mid_next;
    maker_trader   <= mtr_next;
    maker_left     <= mleft_next;
    maker_is_ask   <= mask_next;
    rested_id      <= rid_next;
    last           <= last_next;
  end

  assign taker_id_out = ord_taker;
  assign event_time   = book_clock;

  // Next state and sequencing
  always_comb begin
    state_next           = state;
    book_clock_next      = book_clock;
    order_counter_next   = order_counter;
    arrival_counter_next = arrival_counter;
    ord_market_next      = ord_market;
    ord_sell_next        = ord_sell;
    ord_qty_next         = ord_qty;
    ord_price_next       = ord_price;
    ord_taker_next       = ord_taker;
    ord_id_next          = ord_id;
    out_valid_next       = out_valid;
    kind_next            = result_kind;
    tprice_next          = trade_price;
    tqty_next            = trade_quantity;
    mid_next             = maker_order_id;
    mtr_next             = maker_trader;
    mleft_next           = maker_left;
    mask_next            = maker_is_ask;
    rid_next             = rested_id;
    last_next            = last;
    wr                   = '0;
    wr.op                = WR_SET_QTY;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          book_clock_next = clk_new;
          ord_market_next = (req_type == REQ_MARKET);
          ord_sell_next   = (book_side == SIDE_SELL);
          ord_qty_next    = order_quantity;
          ord_price_next  = limit_price;
          ord_taker_next  = taker_trader;
          ord_id_next     = replay ? replay_order_id : order_counter + 32'd1;
          if (clk_new != '0 && !replay) begin
            order_counter_next = order_counter + 32'd1;
          end
          // Status-only item by default
          out_valid_next = 1'b1;
          tprice_next    = '0;
          tqty_next      = '0;
          mid_next       = '0;
          mtr_next       = '0;
          mleft_next     = '0;
          mask_next      = 1'b0;
          rid_next       = '0;
          last_next      = 1'b1;
          state_next     = ST_EMIT;
          if (clk_new == '0 || req_type > REQ_MARKET || book_side > SIDE_SELL) begin
            kind_next = KIND_REJECT;
          end else if (order_quantity == '0) begin
            kind_next = KIND_DONE;
          end else begin
            out_valid_next = 1'b0;
            state_next     = ST_LAUNCH;
          end
        end
      end
      ST_LAUNCH: begin
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (opp.tok) begin
          out_valid_next = 1'b1;
          state_next     = ST_EMIT;
          tprice_next    = '0;
          tqty_next      = '0;
          mid_next       = '0;
          mtr_next       = '0;
          mleft_next     = '0;
          mask_next      = 1'b0;
          rid_next       = '0;
          last_next      = 1'b1;
          if (opp.found && cross_ok) begin
            // Fill against the best resting order
            kind_next   = KIND_TRADE;
            last_next   = 1'b0;
            tprice_next = opp.price;
            tqty_next   = smaller ? ord_qty : opp.qty;
            mid_next    = opp.oid;
            mtr_next    = opp.trader;
            mleft_next  = smaller ? opp.qty - ord_qty : '0;
            mask_next   = !ord_sell;
            ord_qty_next = smaller ? '0 : ord_qty - opp.qty;
            wr.en  = 1'b1;
            wr.ask = !ord_sell;
            wr.idx = opp.idx;
            wr.op  = smaller ? WR_SET_QTY : WR_CLEAR;
            wr.qty = opp.qty - ord_qty;
          end else if (ord_market) begin
            kind_next = KIND_DONE;
          end else if (!own.free_found) begin
            kind_next = KIND_FULL;
            tqty_next = ord_qty;
          end else begin
            // Rest the remainder in the lowest free slot
            kind_next  = KIND_RESTED;
            tqty_next  = ord_qty;
            rid_next   = ord_id;
            wr.en      = 1'b1;
            wr.ask     = ord_sell;
            wr.idx     = own.free_idx;
            wr.op      = WR_INSERT;
            wr.price   = ord_price;
            wr.qty     = ord_qty;
            wr.oid     = ord_id;
            wr.trader  = ord_taker;
            wr.arrival = arrival_counter;
            arrival_counter_next = arrival_counter + 32'd1;
          end
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          if (last) begin
            out_valid_next = 1'b0;
            state_next     = ST_IDLE;
          end else if (ord_qty == '0) begin
            // Follow the final trade with the status item
            kind_next   = KIND_DONE;
            tprice_next = '0;
            tqty_next   = '0;
            mid_next    = '0;
            mtr_next    = '0;
            mleft_next  = '0;
            mask_next   = 1'b0;
            rid_next    = '0;
            last_next   = 1'b1;
          end else begin
            out_valid_next = 1'b0;
            state_next     = ST_LAUNCH;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/lob_cell.sv @@
// One book slot: holds a resting order and folds it into the passing search.
`default_nettype none
module lob_cell (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          is_ask,
  input  wire  [lob_pkg::IDXW-1:0]     cell_idx,
  input  lob_pkg::wr_t                 wr,
  input  lob_pkg::cand_t               cand_in,
  output lob_pkg::cand_t               cand_out
);
  import lob_pkg::*;

  logic        valid;
  logic [31:0] price;
  logic [31:0] qty;
  logic [31:0] oid;
  logic [31:0] trader;
  logic [31:0] arrival;
  logic        hit;
  logic        better;
  cand_t       cand_next;

  assign hit = wr.en && (wr.ask == is_ask) && (wr.idx == cell_idx);

  // Apply slot writes
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (hit) begin
      case (wr.op)
        WR_SET_QTY: qty <= wr.qty;
        WR_CLEAR:   valid <= 1'b0;
        WR_INSERT: begin
          valid   <= 1'b1;
          price   <= wr.price;
          qty     <= wr.qty;
          oid     <= wr.oid;
          trader  <= wr.trader;
          arrival <= wr.arrival;
        end
        default: valid <= valid;
      endcase
    end
  end

  // Compare this slot against the best seen so far
  always_comb begin
    if (!cand_in.found) begin
      better = 1'b1;
    end else if (price == cand_in.price) begin
      better = arrival < cand_in.arrival;
    end else if (is_ask) begin
      better = price < cand_in.price;
    end else begin
      better = price > cand_in.price;
    end
    cand_next = cand_in;
    if (valid && better) begin
      cand_next.found   = 1'b1;
      cand_next.idx     = cell_idx;
      cand_next.price   = price;
      cand_next.qty     = qty;
      cand_next.oid     = oid;
      cand_next.trader  = trader;
      cand_next.arrival = arrival;
    end
    if (!valid && !cand_in.free_found) begin
      cand_next.free_found = 1'b1;
      cand_next.free_idx   = cell_idx;
    end
  end

  // Hand the search on to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out.tok <= 1'b0;
    end else begin
      cand_out.tok <= cand_in.tok;
    end
    cand_out.found      <= cand_next.found;
    cand_out.idx        <= cand_next.idx;
    cand_out.price      <= cand_next.price;
    cand_out.qty        <= cand_next.qty;
    cand_out.oid        <= cand_next.oid;
    cand_out.trader     <= cand_next.trader;
    cand_out.arrival    <= cand_next.arrival;
    cand_out.free_found <= cand_next.free_found;
    cand_out.free_idx   <= cand_next.free_idx;
  end

endmodule
`default_nettype wire

@@ rtl/lob_chain.sv @@
// One side of the book: a row of slot cells that a search walks through.
`default_nettype none
module lob_chain (
  input  wire             clk,
  input  wire             rst,
  input  wire             is_ask,
  input  wire             seed,
  input  lob_pkg::wr_t    wr,
  output lob_pkg::cand_t  tail
);
  import lob_pkg::*;

  cand_t links [ORDERS_PER_SIDE+1];

  // Start an empty search at the head
  always_comb begin
    links[0]     = '0;
    links[0].tok = seed;
  end

  for (genvar i = 0; i < ORDERS_PER_SIDE; i++) begin : g_cell
    lob_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .is_ask   (is_ask),
      .cell_idx (IDXW'(i)),
      .wr       (wr),
      .cand_in  (links[i]),
      .cand_out (links[i+1])
    );
  end

  assign tail = links[ORDERS_PER_SIDE];

endmodule
`default_nettype wire
